FILE: rtl/core/lsra_pkg.sv
package lsra_pkg;

    localparam int MAX_REGS_DEF = 16;
    localparam int NUM_REGS_W = 5;
    localparam int POS_W = 16;
    localparam int ID_W = 16;
    localparam int SLOT_W = 16;
    localparam int OUT_REG_W = 4;
    localparam logic [NUM_REGS_W-1:0] NUM_REGS_RST = 5'd16;
    localparam logic [SLOT_W-1:0] SLOT_MAX = 16'hFFFF;
    localparam int ENTRY_W = ID_W + POS_W;

    typedef struct packed {
        logic                 got_register;
        logic [OUT_REG_W-1:0] assigned_reg;
        logic [SLOT_W-1:0]    assigned_slot;
        logic                 evicted_valid;
        logic [ID_W-1:0]      evicted_id;
        logic [SLOT_W-1:0]    evicted_slot;
        logic                 slot_overflow;
    } lsra_result_t;

endpackage

FILE: rtl/core/lsra_ram.sv
module lsra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lsra_ctrl.sv
module lsra_ctrl
    import lsra_pkg::*;
#(
    parameter int MAX_REGS = MAX_REGS_DEF,
    localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1,
    localparam int CMP_W = (IDX_W > NUM_REGS_W) ? IDX_W : NUM_REGS_W
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_first,
    input  logic [ID_W-1:0]       in_id,
    input  logic [POS_W-1:0]      in_start,
    input  logic [POS_W-1:0]      in_end,
    input  logic [NUM_REGS_W-1:0] num_regs,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [ENTRY_W-1:0]    ram_wdata,
    output logic [IDX_W-1:0]      ram_raddr,
    input  logic [ENTRY_W-1:0]    ram_rdata,
    input  logic                  res_ready,
    output logic                  res_valid,
    output lsra_result_t          res
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REGS - 1);

    state_t              state_reg, state_next;
    logic [MAX_REGS-1:0] busy_reg, busy_next;
    logic [SLOT_W-1:0]   next_slot_reg, next_slot_next;
    logic [IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic                vic_found_reg, vic_found_next;
    logic [IDX_W-1:0]    vic_idx_reg, vic_idx_next;
    logic [POS_W-1:0]    vic_end_reg, vic_end_next;
    logic [ID_W-1:0]     vic_owner_reg, vic_owner_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [POS_W-1:0]    start_reg, start_next;
    logic [POS_W-1:0]    end_reg, end_next;

    logic [POS_W-1:0] entry_end;
    logic [ID_W-1:0]  entry_owner;
    logic             entry_busy;
    logic             entry_expire;
    logic             entry_live;
    logic             entry_elig;
    logic             do_evict;
    logic             need_slot;
    logic             fin_fire;

    assign entry_end    = ram_rdata[POS_W-1:0];
    assign entry_owner  = ram_rdata[ENTRY_W-1:POS_W];
    assign entry_busy   = busy_reg[cmp_idx_reg];
    assign entry_expire = entry_busy && (entry_end <= start_reg);
    assign entry_live   = entry_busy && !entry_expire;
    assign entry_elig   = CMP_W'(cmp_idx_reg) < CMP_W'(num_regs);

    assign do_evict  = !free_found_reg && vic_found_reg && (vic_end_reg > end_reg);
    assign need_slot = !free_found_reg;
    assign fin_fire  = (state_reg == ST_FINISH) && res_ready;

    assign in_ready  = (state_reg == ST_IDLE);
    assign ram_raddr = rd_idx_reg;
    assign ram_we    = fin_fire && (free_found_reg || do_evict);
    assign ram_waddr = free_found_reg ? free_idx_reg : vic_idx_reg;
    assign ram_wdata = {id_reg, end_reg};
    assign res_valid = fin_fire;

    always_comb begin
        res.got_register  = free_found_reg || do_evict;
        res.assigned_reg  = '0;
        res.assigned_slot = '0;
        res.evicted_valid = do_evict;
        res.evicted_id    = '0;
        res.evicted_slot  = '0;
        res.slot_overflow = need_slot && (next_slot_reg == SLOT_MAX);
        if (free_found_reg) begin
            res.assigned_reg = OUT_REG_W'(free_idx_reg);
        end else if (do_evict) begin
            res.assigned_reg = OUT_REG_W'(vic_idx_reg);
            res.evicted_id   = vic_owner_reg;
            res.evicted_slot = next_slot_reg;
        end else begin
            res.assigned_slot = next_slot_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        next_slot_next  = next_slot_reg;
        rd_idx_next     = rd_idx_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = rd_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        vic_found_next  = vic_found_reg;
        vic_idx_next    = vic_idx_reg;
        vic_end_next    = vic_end_reg;
        vic_owner_next  = vic_owner_reg;
        id_next         = id_reg;
        start_next      = start_reg;
        end_next        = end_reg;

        if (cmp_valid_reg) begin
            if (entry_expire) begin
                busy_next[cmp_idx_reg] = 1'b0;
            end
            if (entry_elig && !entry_live && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
            if (entry_elig && entry_live && (!vic_found_reg || entry_end > vic_end_reg)) begin
                vic_found_next = 1'b1;
                vic_idx_next   = cmp_idx_reg;
                vic_end_next   = entry_end;
                vic_owner_next = entry_owner;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    id_next         = in_id;
                    start_next      = in_start;
                    end_next        = in_end;
                    rd_idx_next     = '0;
                    free_found_next = 1'b0;
                    vic_found_next  = 1'b0;
                    if (in_first) begin
                        busy_next      = '0;
                        next_slot_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_valid_next = 1'b1;
                rd_idx_next    = rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_IDX) begin
                    rd_idx_next = '0;
                    state_next  = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (res_ready) begin
                    if (free_found_reg) begin
                        busy_next[free_idx_reg] = 1'b1;
                    end
                    if (need_slot && next_slot_reg != SLOT_MAX) begin
                        next_slot_next = next_slot_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            next_slot_reg <= '0;
            rd_idx_reg    <= '0;
            cmp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            next_slot_reg <= next_slot_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_valid_reg <= cmp_valid_next;
        end
        cmp_idx_reg    <= cmp_idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        vic_found_reg  <= vic_found_next;
        vic_idx_reg    <= vic_idx_next;
        vic_end_reg    <= vic_end_next;
        vic_owner_reg  <= vic_owner_next;
        id_reg         <= id_next;
        start_reg      <= start_next;
        end_reg        <= end_next;
    end

endmodule

FILE: rtl/core/linear_scan_register_allocator_top.sv
// m_tvalid is registered after the entry scan, which reads one entry per cycle, and the drain and finish states.
// s_tready is high only while the controller is idle, so each interval's entry scan ends before the next is taken.
// The next input transfer is taken while a finished result still waits on the output side.
// Reset (aresetn low, synchronous) clears busy flags, slot counter and the output valid,
// and sets num_regs to 16. Register end and owner storage is not cleared.
module linear_scan_register_allocator_top
    import lsra_pkg::*;
#(
    parameter int MAX_REGS = MAX_REGS_DEF,
    localparam int IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // interval_id, interval_start, interval_end
    input  logic [47:0]           s_tdata,
    // first_of_set
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // assigned_reg, assigned_slot, evicted_id, evicted_slot, zero pad
    output logic [55:0]           m_tdata,
    // got_register, evicted_valid, slot_overflow
    output logic [2:0]            m_tuser,
    input  logic                  cfg_we,
    input  logic [NUM_REGS_W-1:0] cfg_wdata
);

    logic [NUM_REGS_W-1:0] num_regs_reg;
    logic                  m_valid_reg;
    lsra_result_t          out_reg;

    logic                  res_valid;
    logic                  res_ready;
    lsra_result_t          res;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    logic [ENTRY_W-1:0]    ram_rdata;

    assign res_ready = !m_valid_reg || m_tready;

    lsra_ctrl #(
        .MAX_REGS(MAX_REGS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_first  (s_tuser),
        .in_id     (s_tdata[15:0]),
        .in_start  (s_tdata[31:16]),
        .in_end    (s_tdata[47:32]),
        .num_regs  (num_regs_reg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    lsra_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_REGS)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_regs_reg <= NUM_REGS_RST;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_regs_reg <= cfg_wdata;
            end
            if (res_valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_reg.evicted_slot, out_reg.evicted_id,
                       out_reg.assigned_slot, out_reg.assigned_reg};
    assign m_tuser  = {out_reg.slot_overflow, out_reg.evicted_valid, out_reg.got_register};

endmodule

FILE: tb/linear_scan_register_allocator_top_tb.sv
module linear_scan_register_allocator_top_tb
    import lsra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREG = MAX_REGS_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic             first;
        logic [ID_W-1:0]  id;
        logic [POS_W-1:0] st;
        logic [POS_W-1:0] en;
    } interval_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [55:0]           m_tdata;
    logic [2:0]            m_tuser;
    logic                  cfg_we = 1'b0;
    logic [NUM_REGS_W-1:0] cfg_wdata = '0;

    interval_t    interval_q[$];
    lsra_result_t expected_alloc_q[$];
    interval_t    cur_interval;
    lsra_result_t pred_res;
    lsra_result_t want_res;
    lsra_result_t got_res;

    logic                  pm_busy[NREG];
    logic [POS_W-1:0]      pm_end[NREG];
    logic [ID_W-1:0]       pm_owner[NREG];
    logic [SLOT_W-1:0]     pm_next_slot;
    logic [NUM_REGS_W-1:0] pm_num_regs;

    bit idle_on = 1'b1;
    int send_gap = 0;
    int stall_left = 0;
    int cycles = 0;
    int mismatches = 0;
    int n_in = 0;
    int n_out = 0;
    int n_reg = 0;
    int n_evict = 0;
    int n_ovf = 0;
    int n_cfg = 0;

    linear_scan_register_allocator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic void alloc_clear();
        for (int i = 0; i < NREG; i++) begin
            pm_busy[i] = 1'b0;
        end
        pm_next_slot = '0;
    endfunction

    function automatic logic [SLOT_W-1:0] grant_slot(output logic ovf);
        logic [SLOT_W-1:0] s;
        s = pm_next_slot;
        ovf = (pm_next_slot == SLOT_MAX);
        if (!ovf) begin
            pm_next_slot = pm_next_slot + 1'b1;
        end
        return s;
    endfunction

    function automatic lsra_result_t alloc_predict(logic first, logic [ID_W-1:0] id,
                                                   logic [POS_W-1:0] st, logic [POS_W-1:0] en);
        lsra_result_t res;
        int k;
        int pick;
        int victim;
        logic ovf;
        res = '0;
        k = (pm_num_regs > NREG) ? NREG : int'(pm_num_regs);
        if (first) begin
            alloc_clear();
        end
        for (int i = 0; i < NREG; i++) begin
            if (pm_busy[i] && pm_end[i] <= st) begin
                pm_busy[i] = 1'b0;
            end
        end
        pick = -1;
        for (int i = 0; i < k; i++) begin
            if (!pm_busy[i] && pick < 0) begin
                pick = i;
            end
        end
        if (pick >= 0) begin
            pm_busy[pick] = 1'b1;
            pm_end[pick] = en;
            pm_owner[pick] = id;
            res.got_register = 1'b1;
            res.assigned_reg = OUT_REG_W'(pick);
        end else begin
            victim = -1;
            for (int i = 0; i < k; i++) begin
                if (pm_busy[i] && (victim < 0 || pm_end[i] > pm_end[victim])) begin
                    victim = i;
                end
            end
            if (victim >= 0 && pm_end[victim] > en) begin
                res.evicted_valid = 1'b1;
                res.evicted_id = pm_owner[victim];
                res.evicted_slot = grant_slot(ovf);
                res.slot_overflow = ovf;
                pm_end[victim] = en;
                pm_owner[victim] = id;
                res.got_register = 1'b1;
                res.assigned_reg = OUT_REG_W'(victim);
            end else begin
                res.assigned_slot = grant_slot(ovf);
                res.slot_overflow = ovf;
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 60) begin
            return 0;
        end
        if (p < 93) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic int pick_stall();
        int p;
        p = $urandom_range(0, 99);
        if (!idle_on || p < 85) begin
            return 0;
        end
        if (p < 97) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(15, 60);
    endfunction

    function automatic string fmt_result(lsra_result_t r);
        return $sformatf("got=%0b reg=%0d slot=%h ev=%0b ev_id=%h ev_slot=%h ovf=%0b",
                         r.got_register, r.assigned_reg, r.assigned_slot, r.evicted_valid,
                         r.evicted_id, r.evicted_slot, r.slot_overflow);
    endfunction

    task automatic report_error(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("ERROR at cycle %0d: %s", cycles, msg);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
            alloc_clear();
            pm_num_regs = NUM_REGS_RST;
        end else begin
            if (cfg_we) begin
                pm_num_regs = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                pred_res = alloc_predict(s_tuser, s_tdata[15:0],
                                         s_tdata[31:16], s_tdata[47:32]);
                expected_alloc_q = {expected_alloc_q, pred_res};
                n_in++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (interval_q.size() > 0) begin
                cur_interval = interval_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= cur_interval.first;
                s_tdata <= {cur_interval.en, cur_interval.st, cur_interval.id};
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_out++;
                got_res.got_register = m_tuser[0];
                got_res.evicted_valid = m_tuser[1];
                got_res.slot_overflow = m_tuser[2];
                got_res.assigned_reg = m_tdata[3:0];
                got_res.assigned_slot = m_tdata[19:4];
                got_res.evicted_id = m_tdata[35:20];
                got_res.evicted_slot = m_tdata[51:36];
                if (expected_alloc_q.size() == 0) begin
                    report_error({"result with no interval pending: ", fmt_result(got_res)});
                end else begin
                    want_res = expected_alloc_q.pop_front();
                    n_reg += want_res.got_register;
                    n_evict += want_res.evicted_valid;
                    n_ovf += want_res.slot_overflow;
                    if (got_res !== want_res || m_tdata[55:52] !== 4'b0) begin
                        report_error($sformatf("result %0d expected %s, actual %s pad=%h",
                                               n_out, fmt_result(want_res),
                                               fmt_result(got_res), m_tdata[55:52]));
                    end
                end
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                stall_left <= pick_stall();
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results still pending.",
                     cycles, expected_alloc_q.size());
            $display("linear_scan_register_allocator_top verification failed");
            $finish;
        end
    end

    task automatic queue_interval(logic first, logic [ID_W-1:0] id,
                                  logic [POS_W-1:0] st, logic [POS_W-1:0] en);
        interval_t it;
        it.first = first;
        it.id = id;
        it.st = st;
        it.en = en;
        interval_q = {interval_q, it};
    endtask

    task automatic wait_drained();
        while (interval_q.size() > 0 || s_tvalid || expected_alloc_q.size() > 0) begin
            @(negedge aclk);
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_num_regs(int v);
        wait_drained();
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= NUM_REGS_W'(v);
        @(posedge aclk);
        cfg_we <= 1'b0;
        n_cfg++;
        @(negedge aclk);
    endtask

    task automatic add_set(int n, int step_max, int len_max);
        int pos;
        int st;
        int en;
        int p;
        bit fs;
        bit back;
        pos = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 65535))
                                          : int'($urandom_range(0, 200));
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            fs = (i == 0) || (p < 3);
            back = (p >= 3 && p < 8);
            st = pos + int'($urandom_range(0, step_max));
            if (back) begin
                st = pos - int'($urandom_range(1, 50));
            end
            if (st < 0) begin
                st = 0;
            end
            if (st > 65535) begin
                st = 65535;
            end
            if ($urandom_range(0, 9) == 0) begin
                en = st + int'($urandom_range(0, 65535));
            end else begin
                en = st + int'($urandom_range(0, len_max));
            end
            if (en > 65535) begin
                en = 65535;
            end
            if (p >= 8 && p < 14) begin
                en = (st > 0) ? int'($urandom_range(0, st - 1)) : 0;
            end
            queue_interval(fs, ID_W'($urandom_range(0, 65535)), POS_W'(st), POS_W'(en));
            if (!back) begin
                pos = st;
            end
        end
    endtask

    initial begin
        int plan[12];
        int steps[4];
        int lens[3];
        int phase_items;
        int n;
        plan = '{16, 31, 1, 0, 2, 17, 3, 8, 4, 12, 5, 0};
        steps = '{0, 2, 8, 40};
        lens = '{5, 60, 400};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        queue_interval(1'b1, 16'h0000, 16'h0000, 16'h0000);
        queue_interval(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_interval(1'b0, 16'h1234, 16'hFFFF, 16'hFFFF);

        set_num_regs(2);
        queue_interval(1'b1, 16'h0010, 16'd10, 16'd100);
        queue_interval(1'b0, 16'h0011, 16'd11, 16'd50);
        queue_interval(1'b0, 16'h0012, 16'd12, 16'd60);
        queue_interval(1'b0, 16'h0013, 16'd13, 16'd60);
        queue_interval(1'b1, 16'h0020, 16'd20, 16'd90);
        queue_interval(1'b0, 16'h0021, 16'd21, 16'd90);
        queue_interval(1'b0, 16'h0022, 16'd22, 16'd40);
        queue_interval(1'b0, 16'h0023, 16'd5, 16'd6);
        queue_interval(1'b0, 16'h0024, 16'd30, 16'd10);
        queue_interval(1'b0, 16'h0025, 16'd31, 16'd35);

        set_num_regs(4);
        for (int i = 0; i < 4; i++) begin
            queue_interval(i == 0, ID_W'(16'h0030 + i), 16'd0, 16'd1000);
        end
        set_num_regs(2);
        queue_interval(1'b0, 16'h0034, 16'd1, 16'd5);
        queue_interval(1'b0, 16'h0035, 16'd2, 16'd2000);
        queue_interval(1'b0, 16'h0036, 16'd1000, 16'd1001);

        set_num_regs(0);
        queue_interval(1'b1, 16'h0040, 16'd0, 16'd10);
        queue_interval(1'b0, 16'h0041, 16'd1, 16'd20);
        queue_interval(1'b0, 16'h0042, 16'd30, 16'd40);

        for (int ph = 0; ph < 12; ph++) begin
            set_num_regs((ph == 11) ? int'($urandom_range(0, 31)) : plan[ph]);
            idle_on = ($urandom_range(0, 4) != 0);
            phase_items = 0;
            while (phase_items < 48) begin
                n = $urandom_range(3, 30);
                add_set(n, steps[$urandom_range(0, 3)], lens[$urandom_range(0, 2)]);
                phase_items += n;
            end
        end

        set_num_regs(3);
        idle_on = 1'b1;
        queue_interval(1'b0, 16'h0050, 16'd0, 16'd500);
        queue_interval(1'b0, 16'h0051, 16'd0, 16'd600);
        queue_interval(1'b0, 16'h0052, 16'd0, 16'd700);
        queue_interval(1'b0, 16'h0053, 16'd0, 16'd100);
        queue_interval(1'b0, 16'h0054, 16'd0, 16'd900);
        queue_interval(1'b1, 16'h0055, 16'd0, 16'd900);
        add_set(20, 2, 60);

        wait_drained();
        repeat (NREG + 3 + 10) @(negedge aclk);
        if (expected_alloc_q.size() != 0) begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_alloc_q.size()));
        end
        $display("Covered %0d intervals under %0d register-count writes.",
                 n_in, n_cfg);
        $display("Saw %0d register grants, %0d evictions, %0d saturated slots, %0d mismatches.",
                 n_reg, n_evict, n_ovf, mismatches);
        if (mismatches == 0) begin
            $display("linear_scan_register_allocator_top verification clean");
        end else begin
            $display("linear_scan_register_allocator_top verification failed");
        end
        $finish;
    end

endmodule
